[sv/vrsu_pkg.sv]
// vrsu_pkg: shared types and constants of the video register and scroll unit
// command codes, bus register numbers and scroll address masks
// no dependencies
`default_nettype none

package vrsu_pkg;

  // item command codes
  typedef enum logic [2:0] {
    CmdBusRead     = 3'd0,
    CmdBusWrite    = 3'd1,
    CmdIncCoarseX  = 3'd2,
    CmdIncY        = 3'd3,
    CmdCopyHoriz   = 3'd4,
    CmdCopyVert    = 3'd5,
    CmdSetStatus   = 3'd6,
    CmdClearStatus = 3'd7
  } vrsu_cmd_e;

  // bus register numbers
  typedef enum logic [2:0] {
    RegControl    = 3'd0,
    RegMask       = 3'd1,
    RegStatus     = 3'd2,
    RegSprAddr    = 3'd3,
    RegSprData    = 3'd4,
    RegScroll     = 3'd5,
    RegVramAddr   = 3'd6,
    RegVramData   = 3'd7
  } vrsu_reg_e;

  localparam int unsigned SpriteStoreBytes = 256;
  localparam int unsigned SprAddrW         = $clog2(SpriteStoreBytes);

  localparam int unsigned VramAddrW = 15;

  // data port reads below this address go through the read buffer
  localparam logic [VramAddrW-1:0] PaletteBase = 15'h3F00;

  // copy masks from temp to current address
  localparam logic [VramAddrW-1:0] HorizMask = 15'h041F;
  localparam logic [VramAddrW-1:0] VertMask  = 15'h7BE0;

  localparam logic [4:0] CoarseYLastRow = 5'd29;
  localparam logic [4:0] CoarseYMax     = 5'd31;

endpackage

`default_nettype wire

[sv/video_register_scroll_unit_core.sv]
// video_register_scroll_unit_core: bus register front end and scroll address logic
// of a tile video processor, one result per item
// depends on vrsu_pkg
//
// the result of an item is captured in the output register as the item transfers
// throughput: one item per clock while results are taken; the output register frees as its result transfers
// the sprite attribute store is a 256 x 8 memory with a registered read port
// reset: all control, scroll and status registers clear at once, no clearing pass;
// the sprite store holds no reset value and is defined only where written
`default_nettype none

module video_register_scroll_unit_core
  import vrsu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [2:0]  reg_index_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic [7:0]  vram_read_data_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_data_o,
  output logic [14:0]      current_v_o,
  output logic             vram_write_o,
  output logic [7:0]       vram_write_data_o,
  output logic [2:0]       fine_x_scroll_o,
  output logic             nmi_pulse_o,
  output logic [7:0]       control_value_o,
  output logic [7:0]       mask_value_o
);

  // architectural state
  logic [7:0]           control_q, control_d;
  logic [7:0]           mask_q, mask_d;
  logic [7:0]           status_q, status_d;
  logic [SprAddrW-1:0]  spr_addr_q, spr_addr_d;
  logic [VramAddrW-1:0] temp_q, temp_d;
  logic [VramAddrW-1:0] vaddr_q, vaddr_d;
  logic [2:0]           fine_x_q, fine_x_d;
  logic                 toggle_q, toggle_d;
  logic [7:0]           rbuf_q, rbuf_d;
  logic                 nmi_prev_q;

  // output register
  logic                 out_valid_q;
  logic [7:0]           rd_q, rd_d;
  logic                 spr_sel_q, spr_sel_d;
  logic [7:0]           spr_rd_q;
  logic                 vw_q, vw_d;
  logic [7:0]           vwd_q, vwd_d;
  logic                 nmi_pulse_q;

  logic [7:0]           spr_mem [SpriteStoreBytes];

  logic                 accept;
  logic                 spr_we;
  logic                 level;
  logic [VramAddrW-1:0] vaddr_step;
  logic [4:0]           coarse_y;
  vrsu_cmd_e            cmd;
  vrsu_reg_e            reg_idx;

  assign cmd     = vrsu_cmd_e'(cmd_i);
  assign reg_idx = vrsu_reg_e'(reg_index_i);

  // output register parts the two sides
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // data port address step: +32 or +1, kept to 14 bits
  assign vaddr_step = {1'b0, vaddr_q[13:0] + (control_q[2] ? 14'd32 : 14'd1)};
  assign coarse_y   = vaddr_q[9:5];

  // next state and result for one item
  always_comb begin
    control_d = control_q;
    mask_d    = mask_q;
    status_d  = status_q;
    spr_addr_d = spr_addr_q;
    temp_d    = temp_q;
    vaddr_d   = vaddr_q;
    fine_x_d  = fine_x_q;
    toggle_d  = toggle_q;
    rbuf_d    = rbuf_q;
    rd_d      = 8'd0;
    spr_sel_d = 1'b0;
    vw_d      = 1'b0;
    vwd_d     = 8'd0;
    spr_we    = 1'b0;

    unique case (cmd)
      CmdBusRead: begin
        unique case (reg_idx)
          RegStatus: begin
            rd_d        = status_q;
            status_d[7] = 1'b0;
            toggle_d    = 1'b0;
          end
          RegSprData: begin
            spr_sel_d = 1'b1;
          end
          RegVramData: begin
            rd_d    = (vaddr_q < PaletteBase) ? rbuf_q : vram_read_data_i;
            rbuf_d  = vram_read_data_i;
            vaddr_d = vaddr_step;
          end
          default: begin
          end
        endcase
      end
      CmdBusWrite: begin
        unique case (reg_idx)
          RegControl: begin
            control_d      = write_data_i;
            temp_d[11:10]  = write_data_i[1:0];
          end
          RegMask: begin
            mask_d = write_data_i;
          end
          RegSprAddr: begin
            spr_addr_d = write_data_i;
          end
          RegSprData: begin
            spr_we     = 1'b1;
            spr_addr_d = spr_addr_q + 1'b1;
          end
          RegScroll: begin
            if (toggle_q) begin
              temp_d[14:12] = write_data_i[2:0];
              temp_d[9:5]   = write_data_i[7:3];
            end else begin
              fine_x_d     = write_data_i[2:0];
              temp_d[4:0]  = write_data_i[7:3];
            end
            toggle_d = !toggle_q;
          end
          RegVramAddr: begin
            if (toggle_q) begin
              temp_d  = {temp_q[14:8], write_data_i};
              vaddr_d = {temp_q[14:8], write_data_i};
            end else begin
              temp_d = {1'b0, write_data_i[5:0], temp_q[7:0]};
            end
            toggle_d = !toggle_q;
          end
          RegVramData: begin
            vw_d    = 1'b1;
            vwd_d   = write_data_i;
            vaddr_d = vaddr_step;
          end
          default: begin
          end
        endcase
      end
      CmdIncCoarseX: begin
        if (vaddr_q[4:0] == 5'h1F) begin
          vaddr_d = {vaddr_q[14:11], !vaddr_q[10], vaddr_q[9:5], 5'd0};
        end else begin
          vaddr_d[4:0] = vaddr_q[4:0] + 5'd1;
        end
      end
      CmdIncY: begin
        if (vaddr_q[14:12] == 3'd7) begin
          vaddr_d[14:12] = 3'd0;
          priority if (coarse_y == CoarseYLastRow) begin
            vaddr_d[9:5] = 5'd0;
            vaddr_d[11]  = !vaddr_q[11];
          end else if (coarse_y == CoarseYMax) begin
            vaddr_d[9:5] = 5'd0;
          end else begin
            vaddr_d[9:5] = coarse_y + 5'd1;
          end
        end else begin
          vaddr_d[14:12] = vaddr_q[14:12] + 3'd1;
        end
      end
      CmdCopyHoriz: begin
        vaddr_d = (vaddr_q & ~HorizMask) | (temp_q & HorizMask);
      end
      CmdCopyVert: begin
        vaddr_d = (vaddr_q & ~VertMask) | (temp_q & VertMask);
      end
      CmdSetStatus: begin
        status_d = status_q | write_data_i;
      end
      CmdClearStatus: begin
        status_d = 8'd0;
      end
    endcase
  end

  // nmi level after the item
  assign level = status_d[7] && control_d[7];

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q   <= '0;
      mask_q      <= '0;
      status_q    <= '0;
      spr_addr_q  <= '0;
      temp_q      <= '0;
      vaddr_q     <= '0;
      fine_x_q    <= '0;
      toggle_q    <= 1'b0;
      rbuf_q      <= '0;
      nmi_prev_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        control_q  <= control_d;
        mask_q     <= mask_d;
        status_q   <= status_d;
        spr_addr_q <= spr_addr_d;
        temp_q     <= temp_d;
        vaddr_q    <= vaddr_d;
        fine_x_q   <= fine_x_d;
        toggle_q   <= toggle_d;
        rbuf_q     <= rbuf_d;
        nmi_prev_q <= level;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q        <= rd_d;
      spr_sel_q   <= spr_sel_d;
      vw_q        <= vw_d;
      vwd_q       <= vwd_d;
      nmi_pulse_q <= level && !nmi_prev_q;
    end
  end

  // sprite attribute store, registered read
  always_ff @(posedge clk_i) begin
    if (accept && spr_we) begin
      spr_mem[spr_addr_q] <= write_data_i;
    end
    if (accept) begin
      spr_rd_q <= spr_mem[spr_addr_q];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = spr_sel_q ? spr_rd_q : rd_q;
  assign current_v_o       = vaddr_q;
  assign vram_write_o      = vw_q;
  assign vram_write_data_o = vwd_q;
  assign fine_x_scroll_o   = fine_x_q;
  assign nmi_pulse_o       = nmi_pulse_q;
  assign control_value_o   = control_q;
  assign mask_value_o      = mask_q;

endmodule

`default_nettype wire

[sv/vrsu_checker.sv]
// vrsu_checker: port level assertions for the video register and scroll unit
// bound to video_register_scroll_unit_core; depends on vrsu_pkg
`default_nettype none

module vrsu_checker
  import vrsu_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [2:0]  cmd_i,
  input wire logic [2:0]  reg_index_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  read_data_o,
  input wire logic [14:0] current_v_o,
  input wire logic        vram_write_o,
  input wire logic [7:0]  vram_write_data_o,
  input wire logic        nmi_pulse_o,
  input wire logic [7:0]  control_value_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(current_v_o)
      && $stable(read_data_o))
    else $error("stalled result changed");

  // a data port write shows its strobe in the next result
  a_vram_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CmdBusWrite && reg_index_i == RegVramData
      |=> out_valid_o && vram_write_o)
    else $error("data port write lost its strobe");

  // no write byte without a strobe
  a_vwd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !vram_write_o |-> vram_write_data_o == 8'd0)
    else $error("write data without strobe");

  // nmi pulse only with nmi enabled
  a_nmi_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && nmi_pulse_o |-> control_value_o[7])
    else $error("nmi pulse with nmi disabled");

  // items other than bus reads give zero read data
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i != CmdBusRead |=> read_data_o == 8'd0)
    else $error("read data on a non-read item");

endmodule

bind video_register_scroll_unit_core vrsu_checker u_vrsu_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .cmd_i             (cmd_i),
  .reg_index_i       (reg_index_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .read_data_o       (read_data_o),
  .current_v_o       (current_v_o),
  .vram_write_o      (vram_write_o),
  .vram_write_data_o (vram_write_data_o),
  .nmi_pulse_o       (nmi_pulse_o),
  .control_value_o   (control_value_o)
);

`default_nettype wire

[tb/video_register_scroll_unit_core_tb.sv]
// video_register_scroll_unit_core_tb: self-checking bench for the register and scroll unit
// drives bus accesses and render events, predicts every result and compares field by field
// depends on vrsu_pkg and video_register_scroll_unit_core
`default_nettype none

module video_register_scroll_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vrsu_pkg::*;

  localparam int RandItems = 1400;

  typedef struct packed {
    vrsu_cmd_e  cmd;
    vrsu_reg_e  regn;
    logic [7:0] wdata;
    logic [7:0] vdata;
  } scroll_item_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic [14:0] cur_v;
    logic        vwr;
    logic [7:0]  vwdata;
    logic [2:0]  fine_x;
    logic        nmi;
    logic [7:0]  ctrl;
    logic [7:0]  mask;
  } scroll_res_t;

  typedef struct packed {
    scroll_item_t item;
    logic         typed;
    scroll_res_t  res;
  } dir_row_t;

  localparam int DirRows = 29;

  // directed table: typed expectations only where obvious, the rest go through the predictor
  dir_row_t dir_rows [DirRows] = '{
    // status read straight after reset
    '{'{CmdBusRead,  RegStatus,   8'h00, 8'h00}, 1'b1,
      '{8'h00, 15'h0000, 1'b0, 8'h00, 3'd0, 1'b0, 8'h00, 8'h00}},
    // nmi enable and step of 32
    '{'{CmdBusWrite, RegControl,  8'h84, 8'hFF}, 1'b1,
      '{8'h00, 15'h0000, 1'b0, 8'h00, 3'd0, 1'b0, 8'h84, 8'h00}},
    '{'{CmdBusWrite, RegMask,     8'hFF, 8'h00}, 1'b1,
      '{8'h00, 15'h0000, 1'b0, 8'h00, 3'd0, 1'b0, 8'h84, 8'hFF}},
    // status register write is ignored
    '{'{CmdBusWrite, RegStatus,   8'hFF, 8'h00}, 1'b0, '0},
    // vblank with nmi enabled gives the pulse
    '{'{CmdSetStatus, RegControl, 8'h80, 8'h00}, 1'b1,
      '{8'h00, 15'h0000, 1'b0, 8'h00, 3'd0, 1'b1, 8'h84, 8'hFF}},
    '{'{CmdBusRead,  RegStatus,   8'h00, 8'h00}, 1'b0, '0},
    // scroll extremes, then coarse y of 31 wrap and coarse x wrap
    '{'{CmdBusWrite, RegScroll,   8'hFF, 8'h00}, 1'b0, '0},
    '{'{CmdBusWrite, RegScroll,   8'hFF, 8'h00}, 1'b0, '0},
    '{'{CmdCopyVert, RegControl,  8'h00, 8'h00}, 1'b0, '0},
    '{'{CmdIncY,     RegControl,  8'h00, 8'h00}, 1'b0, '0},
    '{'{CmdCopyHoriz, RegControl, 8'h00, 8'h00}, 1'b0, '0},
    '{'{CmdIncCoarseX, RegControl, 8'h00, 8'h00}, 1'b0, '0},
    // coarse y of 29 wraps and switches nametable
    '{'{CmdBusWrite, RegScroll,   8'h00, 8'h00}, 1'b0, '0},
    '{'{CmdBusWrite, RegScroll,   8'hEF, 8'h00}, 1'b0, '0},
    '{'{CmdCopyVert, RegControl,  8'h00, 8'h00}, 1'b0, '0},
    '{'{CmdIncY,     RegControl,  8'h00, 8'h00}, 1'b0, '0},
    // palette read bypasses the buffer
    '{'{CmdBusWrite, RegVramAddr, 8'h3F, 8'h00}, 1'b0, '0},
    '{'{CmdBusWrite, RegVramAddr, 8'h00, 8'h00}, 1'b0, '0},
    '{'{CmdBusRead,  RegVramData, 8'h00, 8'hA5}, 1'b0, '0},
    '{'{CmdBusWrite, RegControl,  8'h00, 8'h00}, 1'b0, '0},
    // buffered read below palette, then a data write
    '{'{CmdBusWrite, RegVramAddr, 8'hC0, 8'h00}, 1'b0, '0},
    '{'{CmdBusWrite, RegVramAddr, 8'h00, 8'h00}, 1'b0, '0},
    '{'{CmdBusRead,  RegVramData, 8'h00, 8'h5A}, 1'b0, '0},
    '{'{CmdBusWrite, RegVramData, 8'hFF, 8'h00}, 1'b0, '0},
    // sprite address wraps after the last entry
    '{'{CmdBusWrite, RegSprAddr,  8'hFF, 8'h00}, 1'b0, '0},
    '{'{CmdBusWrite, RegSprData,  8'h00, 8'h00}, 1'b0, '0},
    '{'{CmdBusWrite, RegSprAddr,  8'hFF, 8'h00}, 1'b0, '0},
    '{'{CmdBusRead,  RegSprData,  8'h00, 8'h00}, 1'b0, '0},
    '{'{CmdClearStatus, RegControl, 8'h00, 8'h00}, 1'b0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  cmd_i = '0;
  logic [2:0]  reg_index_i = '0;
  logic [7:0]  write_data_i = '0;
  logic [7:0]  vram_read_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  read_data_o;
  logic [14:0] current_v_o;
  logic        vram_write_o;
  logic [7:0]  vram_write_data_o;
  logic [2:0]  fine_x_scroll_o;
  logic        nmi_pulse_o;
  logic [7:0]  control_value_o;
  logic [7:0]  mask_value_o;

  video_register_scroll_unit_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_i             (cmd_i),
    .reg_index_i       (reg_index_i),
    .write_data_i      (write_data_i),
    .vram_read_data_i  (vram_read_data_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_data_o       (read_data_o),
    .current_v_o       (current_v_o),
    .vram_write_o      (vram_write_o),
    .vram_write_data_o (vram_write_data_o),
    .fine_x_scroll_o   (fine_x_scroll_o),
    .nmi_pulse_o       (nmi_pulse_o),
    .control_value_o   (control_value_o),
    .mask_value_o      (mask_value_o)
  );

  // shadow state of the unit
  logic [7:0]  ctrl_q = '0;
  logic [7:0]  mask_q = '0;
  logic [7:0]  status_q = '0;
  logic [7:0]  spr_addr_q = '0;
  logic [7:0]  rbuf_q = '0;
  logic [14:0] t_addr_q = '0;
  logic [14:0] v_addr_q = '0;
  logic [2:0]  fine_x_q = '0;
  logic        toggle_q = 1'b0;
  logic        nmi_prev_q = 1'b0;
  logic [7:0]  spr_mem [SpriteStoreBytes];
  bit          spr_written [SpriteStoreBytes];

  scroll_res_t expected_q [$];
  int          error_count = 0;
  int          items_sent = 0;
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // data port address step, 14 bits
  function automatic void step_vram_addr();
    v_addr_q = (v_addr_q + (ctrl_q[2] ? 15'd32 : 15'd1)) & 15'h3FFF;
  endfunction

  // expected result of one item, updating the shadow state
  function automatic scroll_res_t predict_scroll(input scroll_item_t it);
    scroll_res_t r;
    logic [4:0]  cy;
    logic        level;
    r = '0;
    case (it.cmd)
      CmdBusRead: begin
        case (it.regn)
          RegStatus: begin
            r.rdata = status_q;
            status_q[7] = 1'b0;
            toggle_q = 1'b0;
          end
          RegSprData: r.rdata = spr_mem[spr_addr_q];
          RegVramData: begin
            r.rdata = (v_addr_q < PaletteBase) ? rbuf_q : it.vdata;
            rbuf_q = it.vdata;
            step_vram_addr();
          end
          default: ;
        endcase
      end
      CmdBusWrite: begin
        case (it.regn)
          RegControl: begin
            ctrl_q = it.wdata;
            t_addr_q[11:10] = it.wdata[1:0];
          end
          RegMask: mask_q = it.wdata;
          RegSprAddr: spr_addr_q = it.wdata;
          RegSprData: begin
            spr_mem[spr_addr_q] = it.wdata;
            spr_written[spr_addr_q] = 1'b1;
            spr_addr_q = spr_addr_q + 8'd1;
          end
          RegScroll: begin
            if (toggle_q) begin
              t_addr_q[14:12] = it.wdata[2:0];
              t_addr_q[9:5] = it.wdata[7:3];
            end else begin
              fine_x_q = it.wdata[2:0];
              t_addr_q[4:0] = it.wdata[7:3];
            end
            toggle_q = ~toggle_q;
          end
          RegVramAddr: begin
            if (toggle_q) begin
              t_addr_q[7:0] = it.wdata;
              v_addr_q = t_addr_q;
            end else begin
              t_addr_q[14] = 1'b0;
              t_addr_q[13:8] = it.wdata[5:0];
            end
            toggle_q = ~toggle_q;
          end
          RegVramData: begin
            r.vwr = 1'b1;
            r.vwdata = it.wdata;
            step_vram_addr();
          end
          default: ;
        endcase
      end
      CmdIncCoarseX: begin
        if (&v_addr_q[4:0]) begin
          v_addr_q[4:0] = '0;
          v_addr_q[10] = ~v_addr_q[10];
        end else begin
          v_addr_q[4:0] = v_addr_q[4:0] + 5'd1;
        end
      end
      CmdIncY: begin
        if (&v_addr_q[14:12]) begin
          v_addr_q[14:12] = '0;
          cy = v_addr_q[9:5];
          if (cy == CoarseYLastRow) begin
            v_addr_q[9:5] = '0;
            v_addr_q[11] = ~v_addr_q[11];
          end else if (cy == CoarseYMax) begin
            v_addr_q[9:5] = '0;
          end else begin
            v_addr_q[9:5] = cy + 5'd1;
          end
        end else begin
          v_addr_q[14:12] = v_addr_q[14:12] + 3'd1;
        end
      end
      CmdCopyHoriz: v_addr_q = (v_addr_q & ~HorizMask) | (t_addr_q & HorizMask);
      CmdCopyVert:  v_addr_q = (v_addr_q & ~VertMask) | (t_addr_q & VertMask);
      CmdSetStatus: status_q = status_q | it.wdata;
      default:      status_q = '0;
    endcase
    level = status_q[7] & ctrl_q[7];
    r.cur_v = v_addr_q;
    r.fine_x = fine_x_q;
    r.nmi = level & ~nmi_prev_q;
    r.ctrl = ctrl_q;
    r.mask = mask_q;
    nmi_prev_q = level;
    return r;
  endfunction

  // predict, then present the item and wait for its transfer
  task automatic send_item(input scroll_item_t it, input logic use_typed,
                           input scroll_res_t typed);
    scroll_res_t want;
    int          gap;
    // never read a sprite entry that was not written
    if (it.cmd == CmdBusRead && it.regn == RegSprData && !spr_written[spr_addr_q]) begin
      it.regn = RegStatus;
    end
    want = predict_scroll(it);
    expected_q.push_back(use_typed ? typed : want);
    if ($urandom_range(0, 39) == 0) in_burst = ~in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= it.cmd;
    reg_index_i <= it.regn;
    write_data_i <= it.wdata;
    vram_read_data_i <= it.vdata;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
  endtask

  // random memory byte travels with every item
  task automatic send(input vrsu_cmd_e c, input vrsu_reg_e r, input logic [7:0] wd);
    scroll_item_t it;
    it.cmd = c;
    it.regn = r;
    it.wdata = wd;
    it.vdata = 8'($urandom);
    send_item(it, 1'b0, '0);
  endtask

  // one random sequence: mostly well-formed register setups and render runs
  task automatic run_random_sequence();
    int         n;
    logic [7:0] a;
    case ($urandom_range(0, 6))
      0: begin
        // address setup, then data port traffic, sometimes in palette space
        if ($urandom_range(0, 1) == 0) send(CmdBusRead, RegStatus, 8'($urandom));
        a = ($urandom_range(0, 3) == 0) ? (8'h3F | 8'($urandom_range(0, 3) << 6))
                                        : 8'($urandom);
        send(CmdBusWrite, RegVramAddr, a);
        send(CmdBusWrite, RegVramAddr, 8'($urandom));
        n = $urandom_range(1, 4);
        repeat (n) begin
          send(($urandom_range(0, 1) == 0) ? CmdBusRead : CmdBusWrite, RegVramData,
               8'($urandom));
        end
      end
      1: begin
        // scroll pair and a copy into the current address
        if ($urandom_range(0, 3) != 0) send(CmdBusRead, RegStatus, 8'($urandom));
        send(CmdBusWrite, RegScroll, 8'($urandom));
        send(CmdBusWrite, RegScroll, 8'($urandom));
        send(($urandom_range(0, 1) == 0) ? CmdCopyHoriz : CmdCopyVert, RegControl,
             8'($urandom));
      end
      2: begin
        // render run
        n = $urandom_range(1, 8);
        repeat (n) send(vrsu_cmd_e'($urandom_range(2, 5)), vrsu_reg_e'($urandom_range(0, 7)),
                        8'($urandom));
      end
      3: begin
        // sprite writes and a read back of a written entry
        a = 8'($urandom);
        n = $urandom_range(1, 3);
        send(CmdBusWrite, RegSprAddr, a);
        repeat (n) send(CmdBusWrite, RegSprData, 8'($urandom));
        send(CmdBusWrite, RegSprAddr, a + 8'($urandom_range(0, n - 1)));
        send(CmdBusRead, RegSprData, 8'($urandom));
      end
      4: begin
        // control, vblank and status traffic
        send(CmdBusWrite, RegControl, 8'($urandom));
        send(CmdSetStatus, vrsu_reg_e'($urandom_range(0, 7)), 8'($urandom));
        if ($urandom_range(0, 1) == 0) send(CmdBusRead, RegStatus, 8'($urandom));
        if ($urandom_range(0, 3) == 0) send(CmdClearStatus, RegControl, 8'($urandom));
        if ($urandom_range(0, 1) == 0) send(CmdBusWrite, RegMask, 8'($urandom));
      end
      default: begin
        send(vrsu_cmd_e'($urandom_range(0, 7)), vrsu_reg_e'($urandom_range(0, 7)),
             8'($urandom));
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  // compare each result transfer with the oldest expectation
  always @(negedge clk_i) begin
    scroll_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_error("result transfer with nothing expected");
      end else begin
        want = expected_q.pop_front();
        check_field("read_data", read_data_o, want.rdata);
        check_field("current_v", current_v_o, want.cur_v);
        check_field("vram_write", vram_write_o, want.vwr);
        check_field("vram_write_data", vram_write_data_o, want.vwdata);
        check_field("fine_x_scroll", fine_x_scroll_o, want.fine_x);
        check_field("nmi_pulse", nmi_pulse_o, want.nmi);
        check_field("control_value", control_value_o, want.ctrl);
        check_field("mask_value", mask_value_o, want.mask);
      end
    end
  end

  // result side: random stalls per transfer, with stall-free stretches
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = ~out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(negedge clk_i);
      while (!out_valid_o) @(negedge clk_i);
      @(posedge clk_i);
    end
  end

  // reset, directed table, random sequences, drain
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    while (items_sent < DirRows + RandItems) run_random_sequence();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("video_register_scroll_unit_core_tb: PASS");
    end else begin
      $display("video_register_scroll_unit_core_tb: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("video_register_scroll_unit_core_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
